// ===== rtl/pcmv_pkg.sv =====
// package: word types and bfloat16 / single-precision arithmetic helpers
`default_nettype none

package pcmv_pkg;

	localparam int unsigned WordW = 32;
	localparam int unsigned HalfW = 16;

	localparam logic [31:0] CanonNan  = 32'h7FC0_0000;
	localparam logic [30:0] ClampMag  = 31'h3F7D_70A4; // smallest single above 0.99
	localparam logic [31:0] PosOne    = 32'h3F80_0000;
	localparam logic [31:0] NegOne    = 32'hBF80_0000;

	// adder state between the align and the normalize stage
	typedef struct packed {
		logic        special;
		logic [31:0] spec_val;
		logic        sign;
		logic [7:0]  exp;
		logic [26:0] mb;
		logic [26:0] ms;
		logic        sub;
	} add_mid_t;

	// exact bfloat16 product, rounded to single (only underflow rounds)
	function automatic logic [31:0] fmul_bf(input logic [15:0] a, input logic [15:0] b);
		logic        s;
		logic [7:0]  ea, eb, eea, eeb, ma, mb;
		logic        nan_a, nan_b, inf_a, inf_b, zero_a, zero_b;
		logic [15:0] prod;
		logic [4:0]  p;
		logic signed [10:0] esum, bexp, sh, kk;
		logic [4:0]  k;
		logic [23:0] norm, q;
		logic [16:0] pw, mask;
		logic        g, st;
		logic [31:0] res;
		s      = a[15] ^ b[15];
		ea     = a[14:7];
		eb     = b[14:7];
		nan_a  = (ea == 8'hFF) && (a[6:0] != 7'd0);
		nan_b  = (eb == 8'hFF) && (b[6:0] != 7'd0);
		inf_a  = (ea == 8'hFF) && (a[6:0] == 7'd0);
		inf_b  = (eb == 8'hFF) && (b[6:0] == 7'd0);
		zero_a = (ea == 8'h00) && (a[6:0] == 7'd0);
		zero_b = (eb == 8'h00) && (b[6:0] == 7'd0);
		ma     = {ea != 8'h00, a[6:0]};
		mb     = {eb != 8'h00, b[6:0]};
		eea    = (ea == 8'h00) ? 8'd1 : ea;
		eeb    = (eb == 8'h00) ? 8'd1 : eb;
		prod   = ma * mb;
		p      = 5'd0;
		for (int i = 0; i < 16; i++) begin
			if (prod[i]) p = 5'(i);
		end
		esum = $signed({3'b000, eea}) + $signed({3'b000, eeb});
		bexp = esum + $signed({6'b0, p}) - 11'sd141;
		sh   = esum - 11'sd119;
		kk   = -sh;
		k    = (kk > 11'sd17) ? 5'd17 : kk[4:0];
		norm = 24'(prod) << (5'd23 - p);
		pw   = {1'b0, prod};
		mask = (17'h1 << (k - 5'd1)) - 17'h1;
		g    = pw[k - 5'd1];
		st   = |(pw & mask);
		q    = 24'(pw >> k);
		if (nan_a || nan_b || (inf_a && zero_b) || (inf_b && zero_a)) begin
			res = CanonNan;
		end else if (inf_a || inf_b) begin
			res = {s, 8'hFF, 23'd0};
		end else if (prod == 16'd0) begin
			res = {s, 31'd0};
		end else if (bexp >= 11'sd255) begin
			res = {s, 8'hFF, 23'd0};
		end else if (bexp >= 11'sd1) begin
			res = {s, bexp[7:0], norm[22:0]};
		end else if (sh >= 11'sd0) begin
			res = {s, 7'd0, 24'(prod) << sh[4:0]};
		end else begin
			q   = q + {23'd0, g & (st | q[0])};
			res = {s, 7'd0, q};
		end
		return res;
	endfunction

	// single add, first half: specials, ordering and alignment
	function automatic add_mid_t fadd_align(input logic [31:0] a, input logic [31:0] b);
		logic        a_big, nan_a, nan_b, inf_a, inf_b;
		logic [31:0] big, sml;
		logic [7:0]  eb, es, d;
		logic [26:0] ms, shd;
		logic        st;
		add_mid_t    m;
		nan_a = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
		nan_b = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
		inf_a = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
		inf_b = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
		a_big = (a[30:0] >= b[30:0]);
		big   = a_big ? a : b;
		sml   = a_big ? b : a;
		eb    = (big[30:23] == 8'h00) ? 8'd1 : big[30:23];
		es    = (sml[30:23] == 8'h00) ? 8'd1 : sml[30:23];
		d     = eb - es;
		ms    = {sml[30:23] != 8'h00, sml[22:0], 3'b000};
		shd   = ms >> d[4:0];
		st    = |(ms & ~(27'h7FF_FFFF << d[4:0]));
		m.special  = 1'b0;
		m.spec_val = CanonNan;
		if (nan_a || nan_b || (inf_a && inf_b && (a[31] != b[31]))) begin
			m.special = 1'b1;
		end else if (inf_a) begin
			m.special  = 1'b1;
			m.spec_val = a;
		end else if (inf_b) begin
			m.special  = 1'b1;
			m.spec_val = b;
		end
		m.sign = big[31];
		m.exp  = eb;
		m.mb   = {big[30:23] != 8'h00, big[22:0], 3'b000};
		m.ms   = (d >= 8'd27) ? {26'd0, |ms} : {shd[26:1], shd[0] | st};
		m.sub  = a[31] ^ b[31];
		return m;
	endfunction

	// single add, second half: add, normalize, round to nearest even
	function automatic logic [31:0] fadd_norm(input add_mid_t m);
		logic [27:0] sum;
		logic [26:0] v;
		logic [4:0]  lz;
		logic [7:0]  maxsh, sh;
		logic [8:0]  e, fexp;
		logic [24:0] r;
		logic [22:0] frac;
		logic [31:0] res;
		sum = m.sub ? ({1'b0, m.mb} - {1'b0, m.ms}) : ({1'b0, m.mb} + {1'b0, m.ms});
		lz  = 5'd27;
		for (int i = 0; i < 27; i++) begin
			if (sum[i]) lz = 5'(26 - i);
		end
		maxsh = m.exp - 8'd1;
		sh    = ({3'b000, lz} < maxsh) ? {3'b000, lz} : maxsh;
		if (sum[27]) begin
			v = {sum[27:2], sum[1] | sum[0]};
			e = {1'b0, m.exp} + 9'd1;
		end else begin
			v = sum[26:0] << sh[4:0];
			e = {1'b0, m.exp} - {1'b0, sh};
		end
		r = {1'b0, v[26:3]} + {24'd0, v[2] & (v[1] | v[0] | v[3])};
		if (r[24]) begin
			fexp = e + 9'd1;
			frac = r[23:1];
		end else begin
			fexp = r[23] ? e : 9'd0;
			frac = r[22:0];
		end
		if (m.special) begin
			res = m.spec_val;
		end else if (sum == 28'd0) begin
			res = m.sub ? 32'd0 : {m.sign, 31'd0};
		end else if (fexp >= 9'd255) begin
			res = {m.sign, 8'hFF, 23'd0};
		end else begin
			res = {m.sign, fexp[7:0], frac};
		end
		return res;
	endfunction

	// clamp to the unit range, canonical nan, keep the upper half
	function automatic logic [15:0] clamp_trunc(input logic [31:0] v);
		logic [31:0] c;
		if ((v[30:23] == 8'hFF) && (v[22:0] != 23'd0)) begin
			c = CanonNan;
		end else if (v[30:0] >= ClampMag) begin
			c = v[31] ? NegOne : PosOne;
		end else begin
			c = v;
		end
		return c[31:16];
	endfunction

endpackage

`default_nettype wire

// ===== rtl/pcmv_cmul.sv =====
// complex bfloat16 product, three pipeline stages
`default_nettype none

module pcmv_cmul (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic [31:0] gate,
	input  wire logic [31:0] amp,
	output logic             out_valid,
	output logic [31:0]      prod
);

	logic               valid_s1, valid_s2, valid_s3;
	logic [31:0]        ac_s1, bd_s1, ad_s1, bc_s1;
	pcmv_pkg::add_mid_t re_s2, im_s2;
	logic [31:0]        prod_s3;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// partial products, then align, then normalize and clamp
	always_ff @(posedge clk) begin
		ac_s1   <= pcmv_pkg::fmul_bf(gate[15:0], amp[15:0]);
		bd_s1   <= pcmv_pkg::fmul_bf(gate[31:16], amp[31:16]);
		ad_s1   <= pcmv_pkg::fmul_bf(gate[15:0], amp[31:16]);
		bc_s1   <= pcmv_pkg::fmul_bf(gate[31:16], amp[15:0]);
		re_s2   <= pcmv_pkg::fadd_align(ac_s1, {~bd_s1[31], bd_s1[30:0]});
		im_s2   <= pcmv_pkg::fadd_align(ad_s1, bc_s1);
		prod_s3 <= {pcmv_pkg::clamp_trunc(pcmv_pkg::fadd_norm(im_s2)),
			pcmv_pkg::clamp_trunc(pcmv_pkg::fadd_norm(re_s2))};
	end

	assign out_valid = valid_s3;
	assign prod      = prod_s3;

endmodule

`default_nettype wire

// ===== rtl/pcmv_cadd.sv =====
// complex bfloat16 sum, two pipeline stages
`default_nettype none

module pcmv_cadd (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic [31:0] x,
	input  wire logic [31:0] y,
	output logic             out_valid,
	output logic [31:0]      sum
);

	logic               valid_s1, valid_s2;
	pcmv_pkg::add_mid_t re_s1, im_s1;
	logic [31:0]        sum_s2;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	// align, then normalize and clamp
	always_ff @(posedge clk) begin
		re_s1  <= pcmv_pkg::fadd_align({x[15:0], 16'h0000}, {y[15:0], 16'h0000});
		im_s1  <= pcmv_pkg::fadd_align({x[31:16], 16'h0000}, {y[31:16], 16'h0000});
		sum_s2 <= {pcmv_pkg::clamp_trunc(pcmv_pkg::fadd_norm(im_s1)),
			pcmv_pkg::clamp_trunc(pcmv_pkg::fadd_norm(re_s1))};
	end

	assign out_valid = valid_s2;
	assign sum       = sum_s2;

endmodule

`default_nettype wire

// ===== rtl/packed_complex_matvec_2x2.sv =====
// top level: 2x2 complex gate applied to a packed bfloat16 amplitude pair
`default_nettype none

// One word enters per clock and busy never rises: a word taken on start
// shows its result with done after three stages of complex
// multiply, then two stages of complex add. The result is valid
// for one cycle only, so the receiver must take it then; it cannot stall.

module packed_complex_matvec_2x2 (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [31:0] amp_zero,
	input  wire logic [31:0] amp_one,
	input  wire logic [31:0] gate_m00,
	input  wire logic [31:0] gate_m01,
	input  wire logic [31:0] gate_m10,
	input  wire logic [31:0] gate_m11,
	output logic             done,
	output logic [31:0]      new_amp_zero,
	output logic [31:0]      new_amp_one
);

	logic        accept;
	logic [3:0]  mul_valid;
	logic [31:0] p00, p01, p10, p11;
	logic [1:0]  add_valid;

	assign busy   = 1'b0;
	assign accept = start & ~busy;

	// four complex products
	pcmv_cmul u_mul00 (.clk(clk), .arst_n(arst_n), .in_valid(accept), .gate(gate_m00),
		.amp(amp_zero), .out_valid(mul_valid[0]), .prod(p00));
	pcmv_cmul u_mul01 (.clk(clk), .arst_n(arst_n), .in_valid(accept), .gate(gate_m01),
		.amp(amp_one), .out_valid(mul_valid[1]), .prod(p01));
	pcmv_cmul u_mul10 (.clk(clk), .arst_n(arst_n), .in_valid(accept), .gate(gate_m10),
		.amp(amp_zero), .out_valid(mul_valid[2]), .prod(p10));
	pcmv_cmul u_mul11 (.clk(clk), .arst_n(arst_n), .in_valid(accept), .gate(gate_m11),
		.amp(amp_one), .out_valid(mul_valid[3]), .prod(p11));

	// row sums
	pcmv_cadd u_row0 (.clk(clk), .arst_n(arst_n), .in_valid(mul_valid[0]), .x(p00), .y(p01),
		.out_valid(add_valid[0]), .sum(new_amp_zero));
	pcmv_cadd u_row1 (.clk(clk), .arst_n(arst_n), .in_valid(mul_valid[2]), .x(p10), .y(p11),
		.out_valid(add_valid[1]), .sum(new_amp_one));

	assign done = add_valid[0];

`ifndef ASSERT_OFF
	a_lanes_agree: assert property (@(posedge clk) disable iff (!arst_n)
		(mul_valid == 4'h0 || mul_valid == 4'hF) && (add_valid[0] == add_valid[1]))
		else $error("pipeline lanes out of step");
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##5 done)
		else $error("word accepted without result five cycles later");
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |-> ##5 !done)
		else $error("result without an accepted word");
	a_nan_canon: assert property (@(posedge clk) disable iff (!arst_n)
		(done && new_amp_zero[14:7] == 8'hFF && new_amp_zero[6:0] != 7'd0)
		|-> new_amp_zero[15:0] == 16'h7FC0)
		else $error("non-canonical nan on output");
`endif

endmodule

`default_nettype wire
